// ===== design/byte_stream_lexer_defines.svh =====
// Assertion macros used by the lexer design.
`ifndef BYTE_STREAM_LEXER_DEFINES_SVH
`define BYTE_STREAM_LEXER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising clock edge outside reset.
`define BSL_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("lexer check failed");

// Check that a condition implies a consequence in the next cycle.
`define BSL_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lexer sequencing check failed");

`else

`define BSL_ASSERT(name, clk, rst, prop)
`define BSL_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

// ===== design/bsl_pkg.sv =====
// Types and constants of the byte stream lexer.
`timescale 1ns / 1ps
package bsl_pkg;

   // Token kinds
   localparam logic [4:0] TOK_ID      = 5'd0;
   localparam logic [4:0] TOK_INT     = 5'd1;
   localparam logic [4:0] TOK_PRINT   = 5'd2;
   localparam logic [4:0] TOK_IF      = 5'd3;
   localparam logic [4:0] TOK_WHILE   = 5'd4;
   localparam logic [4:0] TOK_NUM     = 5'd5;
   localparam logic [4:0] TOK_EQ      = 5'd6;
   localparam logic [4:0] TOK_PLUS    = 5'd7;
   localparam logic [4:0] TOK_MINUS   = 5'd8;
   localparam logic [4:0] TOK_STAR    = 5'd9;
   localparam logic [4:0] TOK_SLASH   = 5'd10;
   localparam logic [4:0] TOK_ASSIGN  = 5'd11;
   localparam logic [4:0] TOK_SEMI    = 5'd12;
   localparam logic [4:0] TOK_LPAREN  = 5'd13;
   localparam logic [4:0] TOK_RPAREN  = 5'd14;
   localparam logic [4:0] TOK_LBRACE  = 5'd15;
   localparam logic [4:0] TOK_RBRACE  = 5'd16;
   localparam logic [4:0] TOK_INVALID = 5'd17;
   localparam logic [4:0] TOK_EOF     = 5'd18;

   // Input item kinds
   localparam logic ITEM_BYTE = 1'b0;
   localparam logic ITEM_END  = 1'b1;

   // Characters
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_VT     = 8'h0B;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;

   // Keywords, packed first byte most significant
   localparam logic [39:0] KW_INT   = 40'h00_0069_6E74;
   localparam logic [39:0] KW_PRINT = 40'h70_7269_6E74;
   localparam logic [39:0] KW_IF    = 40'h00_0000_6966;
   localparam logic [39:0] KW_WHILE = 40'h77_6869_6C65;

   typedef enum logic [3:0] {
      MODE_IDLE = 4'b0001,
      MODE_WORD = 4'b0010,
      MODE_NUM  = 4'b0100,
      MODE_EQ   = 4'b1000
   } scan_mode_type;

   typedef struct packed {
      logic [4:0]  token_kind;
      logic [15:0] line_number;
      logic [15:0] start_column;
      logic [15:0] lexeme_length;
      logic [7:0]  token_byte;
      logic        last;
   } token_type;

endpackage

// ===== design/bsl_req_if.sv =====
// Input channel of the lexer: one source byte or end of input per transaction.
`timescale 1ns / 1ps
interface bsl_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] char_byte;

   modport source (output valid, output kind, output char_byte, input ready);
   modport sink   (input valid, input kind, input char_byte, output ready);
endinterface

// ===== design/bsl_rsp_if.sv =====
// Result channel of the lexer: one token per transaction.
`timescale 1ns / 1ps
interface bsl_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  token_kind;
   logic [15:0] line_number;
   logic [15:0] start_column;
   logic [15:0] lexeme_length;
   logic [7:0]  token_byte;
   logic        last;

   modport source (output valid, output token_kind, output line_number,
                   output start_column, output lexeme_length, output token_byte,
                   output last, input ready);
   modport sink   (input valid, input token_kind, input line_number,
                   input start_column, input lexeme_length, input token_byte,
                   input last, output ready);
endinterface

// ===== design/byte_stream_lexer.sv =====
// Byte stream lexer: turns a stream of source bytes into tokens.
// Usage:
//  - req_chan carries one source byte (kind 0) or an end-of-input marker (kind 1)
//    per transaction. rsp_chan carries one token per transaction; last marks
//    the final token caused by a request.
//  - A request is evaluated in the cycle it is accepted and its tokens land in
//    a three-entry registered result queue whose head drives rsp_chan.
//  - A byte yields zero, one or two tokens. Throughput is one request per cycle
//    while each request gives at most one token and the receiver does not stall;
//    when requests give two tokens, ready drops between them, set by the single
//    result port draining the queue one token per cycle.
//  - req_chan.ready comes from reset and the queue fill count: it is high out of
//    reset while at most one token waits, so a new request is taken while an
//    earlier token is still held for the receiver.
//  - When the receiver stalls, tokens hold in the queue and ready drops once two
//    or more are waiting; nothing is dropped or reordered.
//  - End of input flushes the pending token, emits EOF with the number of lines
//    read, and returns the scanner to its reset state.
//  - Synchronous reset empties the queue and clears all scanner counters.
//  - Counters saturate at 2^COUNTER_BITS-1; output fields saturate at 65535.
`timescale 1ns / 1ps
`include "byte_stream_lexer_defines.svh"
module byte_stream_lexer #(
   parameter int COUNTER_BITS = 16
) (
   input logic         clock,
   input logic         reset,
   bsl_req_if.sink     req_chan,
   bsl_rsp_if.source   rsp_chan
);

   localparam int QDEPTH = 3;

   // Scanner state
   bsl_pkg::scan_mode_type    mode_ff, mode_in;
   logic [39:0]               prefix_ff, prefix_in;
   logic [COUNTER_BITS-1:0]   tlen_ff, tlen_in;
   logic [COUNTER_BITS-1:0]   tcol_ff, tcol_in;
   logic [COUNTER_BITS-1:0]   ccol_ff, ccol_in;
   logic [COUNTER_BITS-1:0]   lines_ff, lines_in;
   logic                      content_ff, content_in;

   // Result queue, head at entry 0
   bsl_pkg::token_type        queue_ff [QDEPTH];
   bsl_pkg::token_type        queue_in [QDEPTH];
   logic [1:0]                count_ff, count_in;

   logic                      accept;
   logic                      pop;
   logic [1:0]                push_cnt;
   logic [1:0]                base;
   bsl_pkg::token_type        tok_a, tok_b;
   logic                      emit_a, emit_b;

   function automatic logic [COUNTER_BITS-1:0] sat_inc(input logic [COUNTER_BITS-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic logic [15:0] clip16(input logic [COUNTER_BITS-1:0] v);
      logic [COUNTER_BITS+15:0] wide;
      wide = {16'b0, v};
      if (wide[COUNTER_BITS+15:16] != '0) return 16'hFFFF;
      return wide[15:0];
   endfunction

   function automatic logic is_letter(input logic [7:0] b);
      return (b >= 8'd65 && b <= 8'd90) || (b >= 8'd97 && b <= 8'd122);
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b >= 8'd48 && b <= 8'd57;
   endfunction

   function automatic logic [4:0] op_kind(input logic [7:0] b);
      logic [4:0] k;
      case (b)
         bsl_pkg::CH_PLUS:   k = bsl_pkg::TOK_PLUS;
         bsl_pkg::CH_MINUS:  k = bsl_pkg::TOK_MINUS;
         bsl_pkg::CH_STAR:   k = bsl_pkg::TOK_STAR;
         bsl_pkg::CH_SLASH:  k = bsl_pkg::TOK_SLASH;
         bsl_pkg::CH_EQUAL:  k = bsl_pkg::TOK_ASSIGN;
         bsl_pkg::CH_SEMI:   k = bsl_pkg::TOK_SEMI;
         bsl_pkg::CH_LPAREN: k = bsl_pkg::TOK_LPAREN;
         bsl_pkg::CH_RPAREN: k = bsl_pkg::TOK_RPAREN;
         bsl_pkg::CH_LBRACE: k = bsl_pkg::TOK_LBRACE;
         bsl_pkg::CH_RBRACE: k = bsl_pkg::TOK_RBRACE;
         default:            k = bsl_pkg::TOK_INVALID;
      endcase
      return k;
   endfunction

   // Keyword match on the packed word prefix
   function automatic logic [4:0] word_kind(input logic [39:0] pre,
                                            input logic [COUNTER_BITS-1:0] len);
      if (len == COUNTER_BITS'(3) && pre == bsl_pkg::KW_INT)   return bsl_pkg::TOK_INT;
      if (len == COUNTER_BITS'(5) && pre == bsl_pkg::KW_PRINT) return bsl_pkg::TOK_PRINT;
      if (len == COUNTER_BITS'(2) && pre == bsl_pkg::KW_IF)    return bsl_pkg::TOK_IF;
      if (len == COUNTER_BITS'(5) && pre == bsl_pkg::KW_WHILE) return bsl_pkg::TOK_WHILE;
      return bsl_pkg::TOK_ID;
   endfunction

   // Ready depends only on reset and the fill count: room for two more tokens
   assign req_chan.ready = !reset && (count_ff <= 2'd1);
   assign accept         = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid = (count_ff != 2'd0);
   assign pop            = rsp_chan.valid && rsp_chan.ready;

   assign rsp_chan.token_kind    = queue_ff[0].token_kind;
   assign rsp_chan.line_number   = queue_ff[0].line_number;
   assign rsp_chan.start_column  = queue_ff[0].start_column;
   assign rsp_chan.lexeme_length = queue_ff[0].lexeme_length;
   assign rsp_chan.token_byte    = queue_ff[0].token_byte;
   assign rsp_chan.last          = queue_ff[0].last;

   // Scanner: evaluate one request against the current state.
   // tok_a is the flushed pending token, tok_b the token of the byte itself.
   always_comb begin
      logic [7:0]              b;
      logic [COUNTER_BITS-1:0] line1;
      logic                    alnum;
      logic                    flush_ok;
      bsl_pkg::token_type      flush_tok;

      b     = req_chan.char_byte;
      line1 = sat_inc(lines_ff);
      alnum = is_letter(b) || is_digit(b);

      // Pending token as it would be flushed
      flush_tok = '0;
      flush_tok.line_number  = clip16(line1);
      flush_tok.start_column = clip16(tcol_ff);
      flush_ok = 1'b1;
      case (mode_ff)
         bsl_pkg::MODE_WORD: begin
            flush_tok.token_kind    = word_kind(prefix_ff, tlen_ff);
            flush_tok.lexeme_length = clip16(tlen_ff);
         end
         bsl_pkg::MODE_NUM: begin
            flush_tok.token_kind    = bsl_pkg::TOK_NUM;
            flush_tok.lexeme_length = clip16(tlen_ff);
         end
         bsl_pkg::MODE_EQ: begin
            flush_tok.token_kind    = bsl_pkg::TOK_ASSIGN;
            flush_tok.lexeme_length = 16'd1;
            flush_tok.token_byte    = bsl_pkg::CH_EQUAL;
         end
         default: flush_ok = 1'b0;
      endcase

      mode_in    = mode_ff;
      prefix_in  = prefix_ff;
      tlen_in    = tlen_ff;
      tcol_in    = tcol_ff;
      ccol_in    = ccol_ff;
      lines_in   = lines_ff;
      content_in = content_ff;
      tok_a      = flush_tok;
      tok_b      = '0;
      emit_a     = 1'b0;
      emit_b     = 1'b0;

      if (req_chan.kind == bsl_pkg::ITEM_END) begin
         // Flush, report lines read, then return to reset state
         emit_a            = flush_ok;
         emit_b            = 1'b1;
         tok_b.token_kind  = bsl_pkg::TOK_EOF;
         tok_b.line_number = clip16(content_ff ? line1 : lines_ff);
         mode_in    = bsl_pkg::MODE_IDLE;
         prefix_in  = '0;
         tlen_in    = '0;
         tcol_in    = '0;
         ccol_in    = '0;
         lines_in   = '0;
         content_in = 1'b0;
      end else if (b == bsl_pkg::CH_NL) begin
         emit_a     = flush_ok;
         mode_in    = bsl_pkg::MODE_IDLE;
         lines_in   = line1;
         ccol_in    = '0;
         content_in = 1'b0;
      end else begin
         content_in = 1'b1;
         ccol_in    = sat_inc(ccol_ff);
         if (mode_ff == bsl_pkg::MODE_WORD && alnum) begin
            if (tlen_ff < COUNTER_BITS'(5)) prefix_in = {prefix_ff[31:0], b};
            tlen_in = sat_inc(tlen_ff);
         end else if (mode_ff == bsl_pkg::MODE_NUM && is_digit(b)) begin
            tlen_in = sat_inc(tlen_ff);
         end else if (mode_ff == bsl_pkg::MODE_EQ && b == bsl_pkg::CH_EQUAL) begin
            emit_b              = 1'b1;
            tok_b.token_kind    = bsl_pkg::TOK_EQ;
            tok_b.line_number   = clip16(line1);
            tok_b.start_column  = clip16(tcol_ff);
            tok_b.lexeme_length = 16'd2;
            mode_in             = bsl_pkg::MODE_IDLE;
         end else begin
            emit_a  = flush_ok;
            mode_in = bsl_pkg::MODE_IDLE;
            if (b inside {bsl_pkg::CH_TAB, bsl_pkg::CH_VT, bsl_pkg::CH_FF,
                          bsl_pkg::CH_CR, bsl_pkg::CH_SPACE}) begin
               // skip whitespace
            end else if (alnum || b == bsl_pkg::CH_EQUAL) begin
               if (is_letter(b))     mode_in = bsl_pkg::MODE_WORD;
               else if (is_digit(b)) mode_in = bsl_pkg::MODE_NUM;
               else                  mode_in = bsl_pkg::MODE_EQ;
               prefix_in = {32'b0, b};
               tlen_in   = COUNTER_BITS'(1);
               tcol_in   = ccol_ff;
            end else begin
               emit_b              = 1'b1;
               tok_b.token_kind    = op_kind(b);
               tok_b.line_number   = clip16(line1);
               tok_b.start_column  = clip16(ccol_ff);
               tok_b.lexeme_length = 16'd1;
               tok_b.token_byte    = b;
            end
         end
      end

      // Mark the final token of this request
      if (emit_b) tok_b.last = 1'b1;
      else        tok_a.last = 1'b1;
   end

   // Queue update: drop the head on a pop, then append the new tokens
   always_comb begin
      bsl_pkg::token_type shifted [QDEPTH];
      bsl_pkg::token_type first_tok;
      logic [1:0]         n;

      n         = accept ? (2'(emit_a) + 2'(emit_b)) : 2'd0;
      first_tok = emit_a ? tok_a : tok_b;
      push_cnt  = n;
      base      = count_ff - 2'(pop);

      for (int i = 0; i < QDEPTH; i++) begin
         if (pop && i < QDEPTH - 1) shifted[i] = queue_ff[i + 1];
         else                       shifted[i] = queue_ff[i];
      end

      for (int i = 0; i < QDEPTH; i++) begin
         queue_in[i] = shifted[i];
         if (n != 2'd0 && base == 2'(i))          queue_in[i] = first_tok;
         if (n == 2'd2 && base + 2'd1 == 2'(i))   queue_in[i] = tok_b;
      end

      count_in = base + n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= bsl_pkg::MODE_IDLE;
         prefix_ff  <= '0;
         tlen_ff    <= '0;
         tcol_ff    <= '0;
         ccol_ff    <= '0;
         lines_ff   <= '0;
         content_ff <= 1'b0;
         count_ff   <= 2'd0;
      end else begin
         if (accept) begin
            mode_ff    <= mode_in;
            prefix_ff  <= prefix_in;
            tlen_ff    <= tlen_in;
            tcol_ff    <= tcol_in;
            ccol_ff    <= ccol_in;
            lines_ff   <= lines_in;
            content_ff <= content_in;
         end
         count_ff <= count_in;
      end
   end

   // Token payload needs no reset
   always_ff @(posedge clock) begin
      for (int i = 0; i < QDEPTH; i++) queue_ff[i] <= queue_in[i];
   end

   // Queue fill count tracks pops and pushes exactly
   `BSL_ASSERT_NEXT(a_count_track, clock, reset, 1'b1, count_ff == $past(count_ff - 2'(pop) + push_cnt))
   // A pending token only exists on a line that has content
   `BSL_ASSERT(a_pending_has_content, clock, reset, mode_ff == bsl_pkg::MODE_IDLE || content_ff)
   // Word and number tokens are never empty
   `BSL_ASSERT(a_pending_len, clock, reset, !(mode_ff == bsl_pkg::MODE_WORD || mode_ff == bsl_pkg::MODE_NUM) || tlen_ff != '0)
   // End of input returns the scanner to its reset state
   `BSL_ASSERT_NEXT(a_eof_clears, clock, reset, accept && req_chan.kind == bsl_pkg::ITEM_END, mode_ff == bsl_pkg::MODE_IDLE && lines_ff == '0 && ccol_ff == '0)

endmodule
